// ===== src/bffpa_pkg.sv =====
// bffpa_pkg: shared constants, codes and helpers for the best-fit partition allocator
// used by bffpa_ctrl, bffpa_dp and best_fit_fixed_partition_allocator
// no dependencies
`default_nettype none

package bffpa_pkg;

	localparam int NUM_PARTS = 8;
	localparam int SIZE_BITS = 16;
	localparam int IDX_W     = $clog2(NUM_PARTS);
	localparam int CNT_W     = $clog2(NUM_PARTS + 1);

	// fixed field widths of the ports
	localparam int SLOT_W    = 3;
	localparam int REQ_W     = 16;
	localparam int LEFT_W    = 16;
	localparam int PCNT_W    = 4;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int STATUS_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PART_COUNT = 2'd0,
		REG_SIZES_LOW  = 2'd1,
		REG_SIZES_HIGH = 2'd2
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 2'd0,
		ST_NO_FIT   = 2'd1,
		ST_BAD_IDX  = 2'd2,
		ST_ZERO_REQ = 2'd3
	} alloc_status_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic skip_scan;
		logic last;
	} dp_sts_t;

	// size of partition idx from the two packed size registers
	function automatic logic [SIZE_BITS-1:0] part_size(
		input logic [CFG_W-1:0] lo,
		input logic [CFG_W-1:0] hi,
		input logic [IDX_W-1:0] idx
	);
		logic [2*CFG_W-1:0] both;
		logic [15:0]        raw;
		both = {hi, lo};
		raw  = 16'd0;
		if (int'(idx) < 8) begin
			raw = both[16*int'(idx) +: 16];
		end
		return SIZE_BITS'(raw);
	endfunction

endpackage

`default_nettype wire

// ===== src/best_fit_fixed_partition_allocator.sv =====
// best-fit allocator over fixed partitions: controller plus datapath
// an insert runs one load step, one scan step per partition (one size compare each) and one
// result step before the done strobe; remove and zero-size requests skip the scan
// one request at a time; busy stays high until the result word is strobed on done
// asynchronous reset: every partition free, part_count 8, all partition sizes zero
// depends on bffpa_pkg, bffpa_ctrl, bffpa_dp
`default_nettype none

module best_fit_fixed_partition_allocator import bffpa_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 mode,
	input  wire logic [REQ_W-1:0]     request_size,
	input  wire logic [SLOT_W-1:0]    slot,
	output logic                      done,
	output logic [STATUS_W-1:0]       status,
	output logic [SLOT_W-1:0]         chosen_slot,
	output logic [LEFT_W-1:0]         leftover
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	bffpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	bffpa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.mode         (mode),
		.request_size (request_size),
		.slot         (slot),
		.cmd          (cmd),
		.sts          (sts),
		.done         (done),
		.status       (status),
		.chosen_slot  (chosen_slot),
		.leftover     (leftover)
	);

endmodule

`default_nettype wire

// ===== src/bffpa_ctrl.sv =====
// bffpa_ctrl: sequencer for one request: idle, partition scan, result
// depends on bffpa_pkg; drives bffpa_dp through dp_cmd_t
`default_nettype none

module bffpa_ctrl import bffpa_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd,
	output logic         busy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		cmd.load   = (state_q == S_IDLE) && start;
		cmd.scan   = (state_q == S_SCAN);
		cmd.finish = (state_q == S_FINISH);
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_next = sts.skip_scan ? S_FINISH : S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.last) begin
					state_next = S_FINISH;
				end
			end
			S_FINISH: state_next = S_IDLE;
			default:  state_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy    <= 1'b0;
		end else begin
			state_q <= state_next;
			busy    <= (state_next != S_IDLE);
		end
	end

endmodule

`default_nettype wire

// ===== src/bffpa_dp.sv =====
// bffpa_dp: configuration registers, partition occupancy, best-fit scan and result registers
// depends on bffpa_pkg; sequenced by bffpa_ctrl
`default_nettype none

module bffpa_dp import bffpa_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 mode,
	input  wire logic [REQ_W-1:0]     request_size,
	input  wire logic [SLOT_W-1:0]    slot,
	input  wire dp_cmd_t              cmd,
	output dp_sts_t                   sts,
	output logic                      done,
	output logic [STATUS_W-1:0]       status,
	output logic [SLOT_W-1:0]         chosen_slot,
	output logic [LEFT_W-1:0]         leftover
);

	logic [PCNT_W-1:0]    part_count_q;
	logic [CFG_W-1:0]     sizes_lo_q;
	logic [CFG_W-1:0]     sizes_hi_q;
	logic [NUM_PARTS-1:0] used_q;

	logic                 mode_q;
	logic [SIZE_BITS-1:0] req_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_q;
	logic [SIZE_BITS-1:0] best_size_q;

	logic [CNT_W-1:0]     live;
	logic [SIZE_BITS-1:0] cur_size;
	logic                 take;
	logic                 slot_ok;
	logic [SIZE_BITS-1:0] req_in;

	assign req_in = SIZE_BITS'(request_size);

	// counts beyond the partition array act as the full array
	always_comb begin
		if (int'(part_count_q) > NUM_PARTS) begin
			live = CNT_W'(NUM_PARTS);
		end else begin
			live = CNT_W'(part_count_q);
		end
	end

	assign cur_size = part_size(sizes_lo_q, sizes_hi_q, idx_q);
	assign take     = (CNT_W'(idx_q) < live) && !used_q[idx_q] && (cur_size >= req_q)
		&& (!found_q || (cur_size < best_size_q));
	assign slot_ok  = (int'(slot_q) < int'(live));

	assign sts.skip_scan = mode || (req_in == '0);
	assign sts.last      = (idx_q == IDX_W'(NUM_PARTS - 1));

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_count_q <= PCNT_W'(NUM_PARTS);
			sizes_lo_q   <= '0;
			sizes_hi_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PART_COUNT: part_count_q <= cfg_wdata[PCNT_W-1:0];
				REG_SIZES_LOW:  sizes_lo_q   <= cfg_wdata;
				REG_SIZES_HIGH: sizes_hi_q   <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	// request capture and scan
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q      <= mode;
			req_q       <= req_in;
			slot_q      <= slot;
			idx_q       <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			best_size_q <= '0;
		end else if (cmd.scan) begin
			idx_q <= idx_q + 1'b1;
			if (take) begin
				found_q     <= 1'b1;
				best_q      <= idx_q;
				best_size_q <= cur_size;
			end
		end
	end

	// occupancy: a set bit means the partition holds a request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.finish) begin
			if (mode_q) begin
				if (slot_ok) begin
					used_q[IDX_W'(slot_q)] <= 1'b0;
				end
			end else if (req_q != '0 && found_q) begin
				used_q[best_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			priority if (mode_q) begin
				status      <= slot_ok ? ST_DONE : ST_BAD_IDX;
				chosen_slot <= slot_q;
				leftover    <= '0;
			end else if (req_q == '0) begin
				status      <= ST_ZERO_REQ;
				chosen_slot <= '0;
				leftover    <= '0;
			end else if (found_q) begin
				status      <= ST_DONE;
				chosen_slot <= SLOT_W'(best_q);
				leftover    <= LEFT_W'(best_size_q - req_q);
			end else begin
				status      <= ST_NO_FIT;
				chosen_slot <= '0;
				leftover    <= '0;
			end
		end
	end

endmodule

`default_nettype wire
